@@ hw/rtl/sws_pkg.sv @@
// Shared types and codes for the stop-and-wait sender.
package sws_pkg;

    // Item kinds on the input channel
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_ARRIVAL = 2'd1;
    localparam logic [1:0] FUNC_CTRL    = 2'd2;

    // Control message codes
    localparam logic [1:0] CTRL_ACCEPT = 2'd0;
    localparam logic [1:0] CTRL_ACK    = 2'd1;

    // Result actions
    localparam logic [1:0] ACT_NEW    = 2'd0;
    localparam logic [1:0] ACT_RESEND = 2'd1;
    localparam logic [1:0] ACT_DROP   = 2'd2;

    // Configuration register indexes
    localparam int          CFG_IDX_W   = 1;
    localparam logic [0:0]  CFG_TIMEOUT = 1'd0;
    localparam logic [0:0]  CFG_QLIMIT  = 1'd1;

    localparam int DATA_W  = 32;
    localparam int DUR_W   = 16;
    localparam int LIMIT_W = 7;

    // One queued packet
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [DUR_W-1:0]  len;
    } slot_t;

    // One result transaction
    typedef struct packed {
        logic [1:0]        action;
        logic              is_request;
        logic [DATA_W-1:0] data;
        logic [DUR_W-1:0]  duration;
    } res_t;

endpackage

@@ hw/rtl/stop_and_wait_sender.sv @@
// Stop-and-wait sender top level: link control, queue pointers and timers.
//
// The block takes one transaction per clock while not stalled (tick, packet
// arrival or control message) and yields at most one result for it, which
// is registered in the output buffer before the m_ channel. Each item updates
// the control registers; a queued arrival writes the packet queue memory and
// a pop reads it, with the read issued ahead at the next head address, so a
// pop finds its entry ready. Results pass through a two-entry output buffer,
// so input stalls only while two results are waiting to be taken. After
// reset the first tick sends a zero-duration connection request.
module stop_and_wait_sender #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [sws_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sws_pkg::DUR_W-1:0]     cfg_wdata,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_func,
    input  logic [sws_pkg::DATA_W-1:0]    s_pkt_data,
    input  logic [sws_pkg::DUR_W-1:0]     s_pkt_duration,
    input  logic [1:0]                    s_ctrl_code,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_action,
    output logic                          m_is_request,
    output logic [sws_pkg::DATA_W-1:0]    m_out_data,
    output logic [sws_pkg::DUR_W-1:0]     m_out_duration
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > sws_pkg::LIMIT_W) ? CNT_W : sws_pkg::LIMIT_W;
    localparam int DUR_W  = sws_pkg::DUR_W;

    typedef enum logic [1:0] {
        ACK_NAK,
        ACK_OK,
        ACK_PENDING
    } ack_t;

    // Configuration
    logic [DUR_W-1:0]            timeout_reg;
    logic [sws_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= DUR_W'(1000);
            limit_reg   <= sws_pkg::LIMIT_W'(64);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sws_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                sws_pkg::CFG_QLIMIT:  limit_reg   <= cfg_wdata[sws_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Control state
    logic [ADDR_W-1:0]         head_reg, head_next;
    logic [ADDR_W-1:0]         tail_reg, tail_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [sws_pkg::DATA_W-1:0] last_data_reg, last_data_next;
    logic [DUR_W-1:0]          last_len_reg, last_len_next;
    logic                      last_req_reg, last_req_next;
    ack_t                      ack_reg, ack_next;
    logic                      link_reg, link_next;
    logic                      req_pend_reg, req_pend_next;
    logic [DUR_W-1:0]          busy_reg, busy_next;
    logic [DUR_W-1:0]          age_reg, age_next;

    logic            accept;
    logic            drop;
    logic            mem_wr;
    sws_pkg::slot_t  wr_slot;
    sws_pkg::slot_t  head_slot;
    logic            res_valid;
    sws_pkg::res_t   res;
    logic            res_ready;
    sws_pkg::res_t   out_res;

    logic [DUR_W-1:0] age_inc;
    logic [DUR_W-1:0] busy_dec;

    assign s_ready = res_ready;
    assign accept  = s_valid && s_ready;

    assign age_inc  = (age_reg != '1) ? age_reg + 1'b1 : age_reg;
    assign busy_dec = (busy_reg != '0) ? busy_reg - 1'b1 : busy_reg;
    assign drop     = (link_reg && (CMP_W'(count_reg) >= CMP_W'(limit_reg)))
                   || (count_reg == CNT_W'(QUEUE_DEPTH));

    assign wr_slot.data = s_pkt_data;
    assign wr_slot.len  = s_pkt_duration;

    // Per-transaction next state and result
    always_comb begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        last_data_next = last_data_reg;
        last_len_next  = last_len_reg;
        last_req_next  = last_req_reg;
        ack_next       = ack_reg;
        link_next      = link_reg;
        req_pend_next  = req_pend_reg;
        busy_next      = busy_reg;
        age_next       = age_reg;
        mem_wr         = 1'b0;
        res_valid      = 1'b0;
        res.action     = sws_pkg::ACT_NEW;
        res.is_request = 1'b0;
        res.data       = '0;
        res.duration   = '0;

        if (accept) begin
            case (s_func)
                sws_pkg::FUNC_TICK: begin
                    age_next = age_inc;
                    if (req_pend_reg) begin
                        req_pend_next  = 1'b0;
                        res_valid      = 1'b1;
                        res.is_request = 1'b1;
                    end else begin
                        busy_next = busy_dec;
                        if (busy_dec == '0) begin
                            if (link_reg && ack_reg == ACK_OK) begin
                                if (count_reg != '0) begin
                                    res_valid    = 1'b1;
                                    res.data     = head_slot.data;
                                    res.duration = head_slot.len;
                                    count_next   = count_reg - 1'b1;
                                    head_next    = (head_reg == ADDR_W'(QUEUE_DEPTH - 1))
                                                 ? '0 : head_reg + 1'b1;
                                end
                            end else if (ack_reg == ACK_NAK || age_inc >= timeout_reg) begin
                                res_valid      = 1'b1;
                                res.action     = sws_pkg::ACT_RESEND;
                                res.is_request = last_req_reg;
                                res.data       = last_data_reg;
                                res.duration   = last_len_reg;
                            end
                        end
                    end
                    // any send records the packet and restarts the timers
                    if (res_valid) begin
                        last_data_next = res.data;
                        last_len_next  = res.duration;
                        last_req_next  = res.is_request;
                        ack_next       = ACK_PENDING;
                        busy_next      = res.duration;
                        age_next       = '0;
                    end
                end
                sws_pkg::FUNC_ARRIVAL: begin
                    if (drop) begin
                        res_valid    = 1'b1;
                        res.action   = sws_pkg::ACT_DROP;
                        res.data     = s_pkt_data;
                        res.duration = s_pkt_duration;
                    end else begin
                        mem_wr     = 1'b1;
                        count_next = count_reg + 1'b1;
                        tail_next  = (tail_reg == ADDR_W'(QUEUE_DEPTH - 1))
                                   ? '0 : tail_reg + 1'b1;
                    end
                end
                sws_pkg::FUNC_CTRL: begin
                    if (!link_reg && s_ctrl_code == sws_pkg::CTRL_ACCEPT) begin
                        ack_next  = ACK_OK;
                        link_next = 1'b1;
                    end else begin
                        ack_next = (s_ctrl_code == sws_pkg::CTRL_ACK) ? ACK_OK : ACK_NAK;
                    end
                end
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            last_data_reg <= '0;
            last_len_reg  <= '0;
            last_req_reg  <= 1'b1;
            ack_reg       <= ACK_PENDING;
            link_reg      <= 1'b0;
            req_pend_reg  <= 1'b1;
            busy_reg      <= '0;
            age_reg       <= '0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            last_data_reg <= last_data_next;
            last_len_reg  <= last_len_next;
            last_req_reg  <= last_req_next;
            ack_reg       <= ack_next;
            link_reg      <= link_next;
            req_pend_reg  <= req_pend_next;
            busy_reg      <= busy_next;
            age_reg       <= age_next;
        end
    end

    // Queue memory; read runs at the upcoming head so data is ready next cycle
    sws_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr),
        .wr_addr (tail_reg),
        .wr_data (wr_slot),
        .rd_addr (head_next),
        .rd_data (head_slot)
    );

    // Result output buffer
    sws_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_action       = out_res.action;
    assign m_is_request   = out_res.is_request;
    assign m_out_data     = out_res.data;
    assign m_out_duration = out_res.duration;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_request_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == sws_pkg::FUNC_TICK && req_pend_reg) |=> !req_pend_reg)
        else $error("connection request still pending after its tick");

    a_push_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_func == sws_pkg::FUNC_ARRIVAL && !drop) |=> (count_reg != '0))
        else $error("queued arrival left queue empty");

endmodule

@@ hw/rtl/sws_queue.sv @@
// Packet queue memory with registered read and write-to-read forwarding.
module sws_queue #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  sws_pkg::slot_t       wr_data,
    input  logic [ADDR_W-1:0]    rd_addr,
    output sws_pkg::slot_t       rd_data
);

    sws_pkg::slot_t mem [DEPTH];
    sws_pkg::slot_t rd_q_reg;
    sws_pkg::slot_t byp_data_reg;
    logic           byp_valid_reg;

    // Storage write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    // Same-cycle write to the entry being read: memory returns old data, so forward
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else begin
            byp_valid_reg <= wr_en && (wr_addr == rd_addr);
        end
        byp_data_reg <= wr_data;
    end

    assign rd_data = byp_valid_reg ? byp_data_reg : rd_q_reg;

endmodule

@@ hw/rtl/sws_skid.sv @@
// Two-entry output register with skid stage for the result channel.
module sws_skid (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  sws_pkg::res_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output sws_pkg::res_t out_data
);

    sws_pkg::res_t main_reg;
    sws_pkg::res_t skid_reg;
    logic          main_valid_reg;
    logic          skid_valid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Main slot refills from skid first, else from the new transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_reg       <= skid_reg;
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_reg       <= in_data;
                main_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg       <= in_data;
            skid_valid_reg <= 1'b1;
        end
    end

endmodule

@@ sim/tb_stop_and_wait_sender.sv @@
// Self-checking testbench for the stop-and-wait sender: directed table, then random phases.
module tb_stop_and_wait_sender;

    localparam int QDEPTH    = 64;
    localparam int DATA_W    = sws_pkg::DATA_W;
    localparam int DUR_W     = sws_pkg::DUR_W;
    localparam int LIMIT_W   = sws_pkg::LIMIT_W;
    localparam int CFG_IDX_W = sws_pkg::CFG_IDX_W;

    // Codes with no name in the package
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] CTRL_NAK    = 2'd2;
    localparam logic [1:0] CTRL_OTHER  = 2'd3;

    typedef enum logic [1:0] {ST_NAK = 2'd0, ST_ACK = 2'd1, ST_WAIT = 2'd2} ack_e;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} chk_e;

    typedef struct packed {
        logic [1:0]        func;
        logic [DATA_W-1:0] data;
        logic [DUR_W-1:0]  dur;
        logic [1:0]        code;
    } item_t;

    typedef struct {
        item_t         it;
        chk_e          chk;
        sws_pkg::res_t want;
    } row_t;

    typedef struct {
        logic [DUR_W-1:0]   timeout;
        logic [LIMIT_W-1:0] limit;
        int                 arr_pct;
        int                 items;
    } phase_t;

    // DUT signals; the inputs are all known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DUR_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_func = '0;
    logic [DATA_W-1:0]    s_pkt_data = '0;
    logic [DUR_W-1:0]     s_pkt_duration = '0;
    logic [1:0]           s_ctrl_code = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [1:0]           m_action;
    logic                 m_is_request;
    logic [DATA_W-1:0]    m_out_data;
    logic [DUR_W-1:0]     m_out_duration;

    stop_and_wait_sender #(.QUEUE_DEPTH(QDEPTH)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_pkt_data     (s_pkt_data),
        .s_pkt_duration (s_pkt_duration),
        .s_ctrl_code    (s_ctrl_code),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_action       (m_action),
        .m_is_request   (m_is_request),
        .m_out_data     (m_out_data),
        .m_out_duration (m_out_duration)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sender mirror: state as it stands after reset
    sws_pkg::slot_t     q_mem [QDEPTH];
    int unsigned        q_head = 0;
    int unsigned        q_tail = 0;
    int unsigned        q_fill = 0;
    logic [DATA_W-1:0]  last_data = '0;
    logic [DUR_W-1:0]   last_dur = '0;
    logic               last_req = 1'b1;
    ack_e               ack_st = ST_WAIT;
    logic               link_up = 1'b0;
    logic               req_due = 1'b1;
    logic [DUR_W-1:0]   busy_cnt = '0;
    logic [DUR_W-1:0]   age = '0;
    logic [DUR_W-1:0]   timeout_cfg = 16'd1000;
    logic [LIMIT_W-1:0] limit_cfg = 7'd64;

    sws_pkg::res_t pending_results [$];
    int            bad_results = 0;
    bit            src_burst = 1'b0;

    // Any send: remember it, occupy the line, restart the age counter
    function automatic void start_tx(output sws_pkg::res_t r, input logic [1:0] act,
                                     input logic req, input logic [DATA_W-1:0] d,
                                     input logic [DUR_W-1:0] len);
        last_data = d;
        last_dur  = len;
        last_req  = req;
        ack_st    = ST_WAIT;
        busy_cnt  = len;
        age       = '0;
        r = '{act, req, d, len};
    endfunction

    function automatic bit arrival_dropped();
        return (link_up && q_fill >= limit_cfg) || q_fill >= QDEPTH;
    endfunction

    function automatic bit tick_outcome(output sws_pkg::res_t r);
        sws_pkg::slot_t s;
        if (age != 16'hFFFF) age++;
        if (req_due) begin
            req_due = 1'b0;
            start_tx(r, sws_pkg::ACT_NEW, 1'b1, '0, '0);
            return 1'b1;
        end
        if (busy_cnt != 0) busy_cnt--;
        if (busy_cnt != 0) return 1'b0;
        // line idle: next packet after an ack, else resend on nak or timeout
        if (link_up && ack_st == ST_ACK) begin
            if (q_fill == 0) return 1'b0;
            s = q_mem[q_head];
            q_head = (q_head == QDEPTH - 1) ? 0 : q_head + 1;
            q_fill--;
            start_tx(r, sws_pkg::ACT_NEW, 1'b0, s.data, s.len);
            return 1'b1;
        end
        if (ack_st == ST_NAK || age >= timeout_cfg) begin
            start_tx(r, sws_pkg::ACT_RESEND, last_req, last_data, last_dur);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advances the mirror by one transaction; returns 1 when it yields a result
    function automatic bit predict_result(input item_t it, output sws_pkg::res_t r);
        r = '0;
        case (it.func)
            sws_pkg::FUNC_TICK: return tick_outcome(r);
            sws_pkg::FUNC_ARRIVAL: begin
                if (arrival_dropped()) begin
                    r = '{sws_pkg::ACT_DROP, 1'b0, it.data, it.dur};
                    return 1'b1;
                end
                q_mem[q_tail].data = it.data;
                q_mem[q_tail].len  = it.dur;
                q_tail = (q_tail == QDEPTH - 1) ? 0 : q_tail + 1;
                q_fill++;
                return 1'b0;
            end
            sws_pkg::FUNC_CTRL: begin
                // accept opens the link once; afterwards it reads as a nak
                if (!link_up && it.code == sws_pkg::CTRL_ACCEPT) begin
                    ack_st  = ST_ACK;
                    link_up = 1'b1;
                end else begin
                    ack_st = (it.code == sws_pkg::CTRL_ACK) ? ST_ACK : ST_NAK;
                end
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Mostly well-formed traffic: ticks, acks and arrivals with short durations
    function automatic item_t random_item(input int arr_pct);
        item_t it;
        int    k;
        it.data = $urandom;
        it.dur  = DUR_W'($urandom_range(0, 65535));
        it.code = 2'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < arr_pct) begin
            it.func = sws_pkg::FUNC_ARRIVAL;
            // full-range durations only where the packet never reaches the line
            if (!arrival_dropped())
                it.dur = ($urandom_range(0, 7) == 0) ? DUR_W'($urandom_range(4, 12))
                                                     : DUR_W'($urandom_range(0, 3));
        end else begin
            k = $urandom_range(0, 19);
            if (k < 11) it.func = sws_pkg::FUNC_TICK;
            else if (k < 19) it.func = sws_pkg::FUNC_CTRL;
            else it.func = FUNC_UNUSED;
            k = $urandom_range(0, 9);
            if (it.func == sws_pkg::FUNC_CTRL) begin
                if (k < 6) it.code = sws_pkg::CTRL_ACK;
                else if (k < 8) it.code = CTRL_NAK;
                else if (k == 8) it.code = sws_pkg::CTRL_ACCEPT;
                else it.code = CTRL_OTHER;
            end
        end
        return it;
    endfunction

    // One input transaction, then its expected result if any
    task automatic issue_item(input item_t it, input chk_e chk, input sws_pkg::res_t want);
        int            gap;
        sws_pkg::res_t r;
        bit            got;
        gap = src_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= it.func;
        s_pkt_data     <= it.data;
        s_pkt_duration <= it.dur;
        s_ctrl_code    <= it.code;
        do @(posedge aclk); while (!s_ready);
        got = predict_result(it, r);
        if (chk == CHK_RESULT) pending_results.push_back(want);
        else if (chk == CHK_MODEL && got) pending_results.push_back(r);
    endtask

    // Stop sending until every expected result is in, then let the pipe settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [DUR_W-1:0] t, input logic [LIMIT_W-1:0] l);
        logic [DUR_W-1:0] w;
        w = DUR_W'($urandom);
        w[LIMIT_W-1:0] = l;
        cfg_wr_en <= 1'b1;
        cfg_index <= sws_pkg::CFG_TIMEOUT;
        cfg_wdata <= t;
        @(posedge aclk);
        timeout_cfg = t;
        // upper bits of the limit write are don't-care
        cfg_index <= sws_pkg::CFG_QLIMIT;
        cfg_wdata <= w;
        @(posedge aclk);
        limit_cfg = l;
        cfg_wr_en <= 1'b0;
    endtask

    // Directed walk: request, timeouts, nak codes, link set-up, drops at limit zero
    row_t dir_rows [23] = '{
        '{'{FUNC_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, CTRL_OTHER}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT},
          CHK_RESULT, '{sws_pkg::ACT_NEW, 1'b1, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_ARRIVAL, 32'hFFFF_FFFF, 16'd2, CTRL_OTHER}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_ARRIVAL, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_CTRL, 32'h0, 16'h0, sws_pkg::CTRL_ACK}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'hFFFF_FFFF, 16'hFFFF, CTRL_OTHER}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACK}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT},
          CHK_RESULT, '{sws_pkg::ACT_RESEND, 1'b1, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_CTRL, 32'hFFFF_FFFF, 16'hFFFF, CTRL_NAK}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT},
          CHK_RESULT, '{sws_pkg::ACT_RESEND, 1'b1, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_CTRL, 32'h0, 16'h0, CTRL_OTHER}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT},
          CHK_RESULT, '{sws_pkg::ACT_RESEND, 1'b1, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_CTRL, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACK},
          CHK_RESULT, '{sws_pkg::ACT_NEW, 1'b0, 32'hFFFF_FFFF, 16'd2}},
        '{'{sws_pkg::FUNC_CTRL, 32'h0, 16'h0, sws_pkg::CTRL_ACK}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACK}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACK},
          CHK_RESULT, '{sws_pkg::ACT_NEW, 1'b0, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_ARRIVAL, 32'h1234_5678, 16'd1, sws_pkg::CTRL_ACK},
          CHK_RESULT, '{sws_pkg::ACT_DROP, 1'b0, 32'h1234_5678, 16'd1}},
        '{'{sws_pkg::FUNC_ARRIVAL, 32'hFFFF_FFFF, 16'hFFFF, CTRL_OTHER},
          CHK_RESULT, '{sws_pkg::ACT_DROP, 1'b0, 32'hFFFF_FFFF, 16'hFFFF}},
        '{'{sws_pkg::FUNC_CTRL, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT}, CHK_NONE, '0},
        '{'{sws_pkg::FUNC_TICK, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT},
          CHK_RESULT, '{sws_pkg::ACT_RESEND, 1'b0, 32'h0, 16'h0}},
        '{'{sws_pkg::FUNC_TICK, 32'h5A5A_A5A5, 16'h00FF, CTRL_NAK}, CHK_MODEL, '0},
        '{'{FUNC_UNUSED, 32'h0, 16'h0, sws_pkg::CTRL_ACCEPT}, CHK_MODEL, '0}
    };

    // Random phases: zero timeout, limit zero, no timeout, limit past the depth
    phase_t phases [6] = '{
        '{16'd5,     7'd4,   30, 250},
        '{16'd0,     7'd8,   30, 200},
        '{16'd1,     7'd0,   35, 200},
        '{16'd65535, 7'd64,  60, 300},
        '{16'd12,    7'd127, 75, 300},
        '{16'd2,     7'd2,   40, 200}
    };

    // Result sink: random back-pressure with stall-free stretches
    logic [3:0] sink_hold = '0;
    bit         sink_burst = 1'b0;

    always @(posedge aclk) begin : sink_side
        int n;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= '0;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 31) == 0) sink_burst <= !sink_burst;
            n = sink_burst ? 0 : $urandom_range(0, 12);
            if (n != 0) begin
                m_ready   <= 1'b0;
                sink_hold <= 4'(n);
            end
        end else if (!m_ready) begin
            if (sink_hold > 4'd1) sink_hold <= sink_hold - 4'd1;
            else m_ready <= 1'b1;
        end
    end

    // Result check against the oldest expectation
    always @(posedge aclk) begin : result_check
        sws_pkg::res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result: act %0d req %0d data %h dur %h",
                             m_action, m_is_request, m_out_data, m_out_duration);
            end else begin
                e = pending_results.pop_front();
                if (m_action !== e.action || m_is_request !== e.is_request ||
                    m_out_data !== e.data || m_out_duration !== e.duration) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"mismatch: exp act %0d req %0d data %h dur %h,",
                                  " got act %0d req %0d data %h dur %h"},
                                 e.action, e.is_request, e.data, e.duration,
                                 m_action, m_is_request, m_out_data, m_out_duration);
                end
            end
        end
    end

    initial begin : stimulus
        logic [DUR_W-1:0]   t;
        logic [LIMIT_W-1:0] l;
        int                 pct;
        int                 n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        program_regs(16'd3, 7'd0);

        foreach (dir_rows[i])
            issue_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);

        for (int p = 0; p < 8; p++) begin
            if (p < 6) begin
                t   = phases[p].timeout;
                l   = phases[p].limit;
                pct = phases[p].arr_pct;
                n   = phases[p].items;
            end else begin
                t   = DUR_W'($urandom_range(1, 20));
                l   = LIMIT_W'($urandom_range(0, 64));
                pct = 40;
                n   = 250;
            end
            drain_results();
            program_regs(t, l);
            for (int i = 0; i < n; i++) begin
                // occasional full stop mid-phase
                if ($urandom_range(0, 149) == 0) drain_results();
                issue_item(random_item(pct), CHK_MODEL, '0);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);
        if (bad_results == 0 && pending_results.size() == 0)
            $display("tb_stop_and_wait_sender OK");
        else
            $display("tb_stop_and_wait_sender NOT OK");
        $finish;
    end

    // Watchdog
    initial begin
        #5000000;
        $display("tb_stop_and_wait_sender NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sws_pkg.sv
hw/rtl/sws_queue.sv
hw/rtl/sws_skid.sv
hw/rtl/stop_and_wait_sender.sv
sim/tb_stop_and_wait_sender.sv
